// ----- design/wsfhp_pkg.sv -----
// Shared types and constants for the WebSocket frame header parser.
package wsfhp_pkg;

    // Parser phase: which header byte is expected next
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_EXTLEN = 2'd2,
        PH_KEY    = 2'd3
    } phase_t;

    // Status codes of a finished header
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RESERVED  = 2'd1,
        ST_TOO_LONG  = 2'd2,
        ST_BAD_OPCODE = 2'd3
    } status_t;

    // Configuration register indexes
    localparam logic CFG_MAX_LONG_LENGTH   = 1'b0;
    localparam logic CFG_OPCODE_ACCEPT_MASK = 1'b1;

    localparam logic [30:0] MAX_LONG_LENGTH_RST    = 31'h7FFF_FFFF;
    localparam logic [15:0] OPCODE_ACCEPT_MASK_RST = 16'h0107;

    // Seven-bit length codes that announce an extended length
    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    // One decoded header
    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  header_length;
        logic [30:0] payload_length;
        logic [31:0] mask_key;
        logic        mask_flag;
        logic [3:0]  frame_opcode;
        logic        fin_flag;
    } result_t;

    // Step request into the parser core and its answer
    typedef struct packed {
        logic       step;
        logic [7:0] data_byte;
    } core_req_t;

    typedef struct packed {
        logic    done;
        result_t result;
    } core_rsp_t;

endpackage

// ----- design/wsfhp_core.sv -----
// Header parser state and per-byte decode of the WebSocket frame header.
module wsfhp_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  wsfhp_pkg::core_req_t req,
    input  logic [30:0]         max_long_length,
    input  logic [15:0]         opcode_accept_mask,
    output wsfhp_pkg::core_rsp_t rsp
);

    wsfhp_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  bytes_left_reg, bytes_left_next;
    logic        fin_reg, fin_next;
    logic [2:0]  reserved_reg, reserved_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_flag_reg, mask_flag_next;
    logic [6:0]  short_len_reg, short_len_next;
    logic [63:0] ext_len_reg, ext_len_next;
    logic [31:0] key_reg, key_next;
    logic [3:0]  byte_count_reg, byte_count_next;
    logic        done;
    logic [7:0]  b;
    logic        too_long;
    logic [30:0] len;
    wsfhp_pkg::status_t status;

    assign b = req.data_byte;

    always_comb begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        fin_next        = fin_reg;
        reserved_next   = reserved_reg;
        opcode_next     = opcode_reg;
        mask_flag_next  = mask_flag_reg;
        short_len_next  = short_len_reg;
        ext_len_next    = ext_len_reg;
        key_next        = key_reg;
        byte_count_next = byte_count_reg;
        done            = 1'b0;
        case (phase_reg)
            wsfhp_pkg::PH_SECOND: begin
                mask_flag_next  = b[7];
                short_len_next  = b[6:0];
                ext_len_next    = '0;
                key_next        = '0;
                byte_count_next = 4'd2;
                if (b[6:0] == wsfhp_pkg::LEN_CODE_16) begin
                    bytes_left_next = wsfhp_pkg::EXT16_BYTES;
                    phase_next      = wsfhp_pkg::PH_EXTLEN;
                end else if (b[6:0] == wsfhp_pkg::LEN_CODE_64) begin
                    bytes_left_next = wsfhp_pkg::EXT64_BYTES;
                    phase_next      = wsfhp_pkg::PH_EXTLEN;
                end else if (b[7]) begin
                    bytes_left_next = wsfhp_pkg::KEY_BYTES;
                    phase_next      = wsfhp_pkg::PH_KEY;
                end else begin
                    done = 1'b1;
                end
            end
            wsfhp_pkg::PH_EXTLEN: begin
                ext_len_next    = {ext_len_reg[55:0], b};
                byte_count_next = byte_count_reg + 4'd1;
                bytes_left_next = bytes_left_reg - 4'd1;
                if (bytes_left_next == 4'd0) begin
                    if (mask_flag_reg) begin
                        bytes_left_next = wsfhp_pkg::KEY_BYTES;
                        phase_next      = wsfhp_pkg::PH_KEY;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
            wsfhp_pkg::PH_KEY: begin
                key_next        = {key_reg[23:0], b};
                byte_count_next = byte_count_reg + 4'd1;
                bytes_left_next = bytes_left_reg - 4'd1;
                if (bytes_left_next == 4'd0) begin
                    done = 1'b1;
                end
            end
            default: begin
                fin_next        = b[7];
                reserved_next   = b[6:4];
                opcode_next     = b[3:0];
                mask_flag_next  = 1'b0;
                short_len_next  = '0;
                ext_len_next    = '0;
                key_next        = '0;
                byte_count_next = 4'd1;
                bytes_left_next = '0;
                phase_next      = wsfhp_pkg::PH_SECOND;
            end
        endcase
        // a finished header sends the parser back to the first byte
        if (done) begin
            phase_next      = wsfhp_pkg::PH_FIRST;
            bytes_left_next = '0;
        end
    end

    // Result fields from the post-step header values
    always_comb begin
        too_long = (|ext_len_next[63:31]) || (ext_len_next[30:0] > max_long_length);
        if (short_len_next == wsfhp_pkg::LEN_CODE_16) begin
            len = {15'd0, ext_len_next[15:0]};
        end else if (short_len_next == wsfhp_pkg::LEN_CODE_64) begin
            len = ext_len_next[30:0];
        end else begin
            len = {24'd0, short_len_next};
        end
        if (reserved_next != 3'd0) begin
            status = wsfhp_pkg::ST_RESERVED;
        end else if (short_len_next == wsfhp_pkg::LEN_CODE_64 && too_long) begin
            status = wsfhp_pkg::ST_TOO_LONG;
        end else if (!opcode_accept_mask[opcode_next]) begin
            status = wsfhp_pkg::ST_BAD_OPCODE;
        end else begin
            status = wsfhp_pkg::ST_OK;
        end
        rsp.done                  = done;
        rsp.result.fin_flag       = fin_next;
        rsp.result.frame_opcode   = opcode_next;
        rsp.result.mask_flag      = mask_flag_next;
        rsp.result.mask_key       = mask_flag_next ? key_next : 32'd0;
        rsp.result.payload_length = (status == wsfhp_pkg::ST_OK) ? len : 31'd0;
        rsp.result.header_length  = byte_count_next;
        rsp.result.status         = status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= wsfhp_pkg::PH_FIRST;
            bytes_left_reg <= '0;
            fin_reg        <= 1'b0;
            reserved_reg   <= '0;
            opcode_reg     <= '0;
            mask_flag_reg  <= 1'b0;
            short_len_reg  <= '0;
            ext_len_reg    <= '0;
            key_reg        <= '0;
            byte_count_reg <= '0;
        end else if (req.step) begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            fin_reg        <= fin_next;
            reserved_reg   <= reserved_next;
            opcode_reg     <= opcode_next;
            mask_flag_reg  <= mask_flag_next;
            short_len_reg  <= short_len_next;
            ext_len_reg    <= ext_len_next;
            key_reg        <= key_next;
            byte_count_reg <= byte_count_next;
        end
    end

endmodule

// ----- design/websocket_frame_header_parser_top.sv -----
// Top level of the WebSocket frame header parser: stream ports, config, staging.
//
//  channel   | ports               | payload
//  ----------+---------------------+---------------------------------------------
//  input     | s_tvalid/tready     | s_tdata[7:0]  : data_byte
//  result    | m_tvalid/tready     | m_tdata[79:0] : header fields, one per header
//  config    | cfg_wr_en/index     | cfg_wdata[30:0], no read-back
//
// One header byte is taken per cycle while no stalled result holds the byte that
// finishes a header; a transaction moves from the input register through the
// parser core into the result register in one step.
// Reset (aresetn low, synchronous) empties both registers, returns the parser
// to the first header byte and restores both config registers.
// A stalled result holds only the byte that would finish the next header;
// all other bytes keep advancing.
module websocket_frame_header_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,    // [0] fin_flag, [4:1] frame_opcode, [5] mask_flag,
                                    // [37:6] mask_key, [68:38] payload_length,
                                    // [72:69] header_length, [74:73] status, [79:75] zero
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [30:0] cfg_wdata
);

    logic [30:0] max_long_length_reg;
    logic [15:0] opcode_accept_mask_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    wsfhp_pkg::result_t out_result_reg;

    wsfhp_pkg::core_req_t core_req;
    wsfhp_pkg::core_rsp_t core_rsp;
    logic out_free;
    logic consume;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_long_length_reg    <= wsfhp_pkg::MAX_LONG_LENGTH_RST;
            opcode_accept_mask_reg <= wsfhp_pkg::OPCODE_ACCEPT_MASK_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                wsfhp_pkg::CFG_MAX_LONG_LENGTH:    max_long_length_reg <= cfg_wdata;
                wsfhp_pkg::CFG_OPCODE_ACCEPT_MASK: opcode_accept_mask_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Drain the staged byte unless it finishes a header while the result is stuck
    assign out_free = !out_valid_reg || m_tready;
    assign consume  = in_valid_reg && (!core_rsp.done || out_free);
    assign s_tready = !in_valid_reg || consume;

    assign core_req.step      = consume;
    assign core_req.data_byte = in_byte_reg;

    wsfhp_core u_core (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .req                (core_req),
        .max_long_length    (max_long_length_reg),
        .opcode_accept_mask (opcode_accept_mask_reg),
        .rsp                (core_rsp)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Result register: load on a finished header, drop on hand-off
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (consume && core_rsp.done) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && core_rsp.done) begin
            out_result_reg <= core_rsp.result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0,
                       out_result_reg.status,
                       out_result_reg.header_length,
                       out_result_reg.payload_length,
                       out_result_reg.mask_key,
                       out_result_reg.mask_flag,
                       out_result_reg.frame_opcode,
                       out_result_reg.fin_flag};

endmodule
